// File: hdl/mfr_pkg.sv
package mfr_pkg;

    // word format and field widths
    localparam int W         = 32;
    localparam int FRAC      = 16;
    localparam int LEN_W     = 31;
    localparam int KAPPA_W   = 18;
    localparam int MODE_W    = 2;
    localparam int EPS_W     = 16;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    // stream payload widths, whole bytes
    localparam int IN_TDATA_W  = ((3 * W + 3 * LEN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((W + 1 + 7) / 8) * 8;

    // divider: operand width, quotient bits per step, latency
    localparam int DIV_N     = LEN_W + 3;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = W / DIV_BITS;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // input register, four divider phases, twelve short stages, output register
    localparam int PIPE_LAT = 4 * DIV_LAT + 14;

    // limiter codes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VA   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MM   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd2;

    typedef logic signed [W-1:0]     word_t;
    typedef logic signed [DIV_N-1:0] dop_t;

    typedef struct packed {
        logic  flag;
        word_t val;
    } res_t;

    typedef struct packed {
        logic           neg;
        logic [2*W-1:0] mag;
    } prod_t;

    localparam word_t WMAX    = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN    = {1'b1, {(W-1){1'b0}}};
    localparam word_t ONE     = word_t'(1) <<< FRAC;
    localparam word_t THREE   = word_t'(3) <<< FRAC;
    localparam word_t QUARTER = word_t'(1) <<< (FRAC - 2);

    // saturating add
    function automatic res_t q_add(input word_t x, input word_t y);
        logic signed [W:0] s;
        res_t r;
        s = {x[W-1], x} + {y[W-1], y};
        r.flag = s[W] ^ s[W-1];
        r.val = r.flag ? (s[W] ? WMIN : WMAX) : s[W-1:0];
        return r;
    endfunction

    // saturating subtract
    function automatic res_t q_sub(input word_t x, input word_t y);
        logic signed [W:0] s;
        res_t r;
        s = {x[W-1], x} - {y[W-1], y};
        r.flag = s[W] ^ s[W-1];
        r.val = r.flag ? (s[W] ? WMIN : WMAX) : s[W-1:0];
        return r;
    endfunction

    // first half of a product: sign and magnitude product
    function automatic prod_t mul_mag(input word_t x, input word_t y);
        logic [W-1:0] mx;
        logic [W-1:0] my;
        prod_t p;
        mx = x[W-1] ? (~x + 1'b1) : x;
        my = y[W-1] ? (~y + 1'b1) : y;
        p.neg = x[W-1] ^ y[W-1];
        p.mag = mx * my;
        return p;
    endfunction

    // second half of a product: round half away, clamp, apply sign
    function automatic res_t mul_fin(input prod_t p);
        logic [2*W-1:0] m;
        logic [2*W-1:0] lim;
        res_t r;
        m = (p.mag + ((2*W)'(1) << (FRAC - 1))) >> FRAC;
        lim = ((2*W)'(1) << (W - 1)) - (2*W)'(!p.neg);
        r.flag = (m > lim);
        if (r.flag)
        begin
            m = lim;
        end
        r.val = p.neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
        return r;
    endfunction

    function automatic word_t w_max(input word_t x, input word_t y);
        return (x > y) ? x : y;
    endfunction

    function automatic word_t w_min(input word_t x, input word_t y);
        return (x < y) ? x : y;
    endfunction

endpackage

// File: hdl/mfr_div.sv
module mfr_div
    import mfr_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  dop_t  num,
    input  dop_t  den,
    output word_t quo,
    output logic  sat
);

    typedef struct packed {
        logic             neg;
        logic             num_neg;
        logic             zero;
        logic             big;
        logic [DIV_N-1:0] dvs;
        logic [DIV_N:0]   rem;
        logic [W-1:0]     low;
        logic [W-1:0]     q;
    } dstep_t;

    dstep_t           st_reg [DIV_STEPS+1];
    dstep_t           setup;
    dstep_t           last;
    logic [DIV_N-1:0] n_mag;
    logic [DIV_N-1:0] d_mag;
    logic [W:0]       qr;
    logic [W:0]       lim;
    logic [W:0]       m;
    word_t            quo_reg;
    word_t            quo_next;
    logic             sat_reg;
    logic             sat_next;

    // restoring long division, DIV_BITS quotient bits per step
    function automatic dstep_t div_step(input dstep_t s);
        dstep_t t;
        logic [DIV_N:0] r2;
        t = s;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r2 = {t.rem[DIV_N-1:0], t.low[W-1]};
            t.low = {t.low[W-2:0], 1'b0};
            if (r2 >= {1'b0, t.dvs})
            begin
                t.rem = r2 - {1'b0, t.dvs};
                t.q = {t.q[W-2:0], 1'b1};
            end
            else
            begin
                t.rem = r2;
                t.q = {t.q[W-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    // magnitudes, overflow check, top part of the scaled dividend
    always_comb
    begin
        n_mag = num[DIV_N-1] ? (~num + 1'b1) : num;
        d_mag = den[DIV_N-1] ? (~den + 1'b1) : den;
        setup.neg = num[DIV_N-1] ^ den[DIV_N-1];
        setup.num_neg = num[DIV_N-1];
        setup.zero = (d_mag == '0);
        setup.big = ({n_mag, {FRAC{1'b0}}} >= {d_mag, {W{1'b0}}});
        setup.dvs = d_mag;
        setup.rem = (DIV_N+1)'(n_mag >> (W - FRAC));
        setup.low = {n_mag[W-FRAC-1:0], {FRAC{1'b0}}};
        setup.q = '0;
    end

    // rounding, clamping, sign and the divide-by-zero result
    always_comb
    begin
        last = st_reg[DIV_STEPS];
        qr = {1'b0, last.q} + (W+1)'({last.rem, 1'b0} >= last.dvs);
        lim = ((W+1)'(1) << (W - 1)) - (W+1)'(!last.neg);
        m = qr;
        sat_next = 1'b0;
        if (last.big || (qr > lim))
        begin
            m = lim;
            sat_next = 1'b1;
        end
        quo_next = last.neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
        if (last.zero)
        begin
            sat_next = 1'b1;
            quo_next = last.num_neg ? WMIN : WMAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= setup;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                st_reg[i+1] <= div_step(st_reg[i]);
            end
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

// File: hdl/muscl_face_reconstruction_top.sv
// an item passes the input register, four serial division phases, the short
// stages and the output register; throughput: one item per cycle unless stalled;
// division phases use 18-stage pipelined dividers retiring two quotient bits per
// step; a stalled output freezes the whole pipeline, nothing is dropped
// reset: valid bits cleared, kappa 0, limiter none, eps_bias 1; payload not reset
module muscl_face_reconstruction_top
    import mfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // value_far_upwind, value_near_upwind, value_downwind,
    // len_near_upwind, len_far_upwind, len_downwind, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // face_value, saturated, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef struct packed {
        word_t            u2;
        word_t            u1;
        word_t            dv;
        logic [LEN_W-1:0] len1;
        logic [LEN_W-1:0] len2;
        logic [LEN_W-1:0] lend;
    } in_t;

    typedef struct packed {
        word_t u1;
        word_t a;
        word_t b;
        word_t pa;
        word_t nr;
        word_t dr;
        word_t r;
        word_t lim_mm;
        word_t mi;
        word_t lim_va;
        word_t s;
        word_t vn;
        word_t vd;
        word_t sn;
        word_t sd;
        word_t lim;
        word_t inv;
        word_t c1;
        word_t c2;
        word_t adm;
        word_t t1;
        word_t t2a;
        word_t bkt;
        prod_t p0;
        prod_t p1;
        prod_t p2;
        logic  fl_c;
        logic  fl_v;
        logic  fl_m;
    } ctx_t;

    // configuration
    logic signed [KAPPA_W-1:0] kappa_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic [EPS_W-1:0]          eps_reg;
    word_t                     k_w;
    word_t                     eps_w;

    // pipeline control
    logic [PIPE_LAT-1:0] vld_reg;
    logic                pipe_en;

    // pipeline payload
    in_t   in_reg;
    ctx_t  d1_reg [DIV_LAT];
    ctx_t  d2_reg [DIV_LAT];
    ctx_t  d3_reg [DIV_LAT];
    ctx_t  d4_reg [DIV_LAT];
    ctx_t  m1a_reg, m1b_reg, m2a_reg, m2b_reg, m3a_reg, m3b_reg;
    ctx_t  f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    ctx_t  d1_next, m1a_next, m1b_next, m2a_next, m2b_next, m3a_next, m3b_next;
    ctx_t  f1_next, f2_next, f3_next, f4_next, f5_next, f6_next;
    word_t face_reg, face_next;
    logic  sat_reg, sat_next;

    // divider operands and results
    res_t  beta_num, beta_den;
    dop_t  dp_num, dp_den, dm_den;
    word_t dp_q, dm_q, beta_q, r_q, va1_q, inv_q, mi_q, va2_q;
    logic  dp_f, dm_f, beta_f, r_f, va1_f, inv_f, mi_f, va2_f;

    function automatic word_t minmod(input word_t a, input word_t bb);
        word_t l;
        l = '0;
        if (a > 0)
        begin
            l = w_max('0, w_min(a, bb));
        end
        else if (a < 0)
        begin
            l = w_min('0, w_max(a, bb));
        end
        return l;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg <= '0;
            mode_reg  <= MODE_NONE;
            eps_reg   <= EPS_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_KAPPA: kappa_reg <= cfg_data[KAPPA_W-1:0];
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_EPS:   eps_reg   <= cfg_data[EPS_W-1:0];
                default:   ;
            endcase
        end
    end

    assign k_w   = word_t'(kappa_reg);
    assign eps_w = word_t'(eps_reg);

    // whole pipeline advances unless a result waits
    assign pipe_en       = !vld_reg[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = vld_reg[PIPE_LAT-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W-W-1){1'b0}}, sat_reg, face_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    // differences, grid factor and beta operands
    assign beta_num = q_sub(THREE, k_w);
    assign beta_den = q_sub(ONE, k_w);
    assign dp_num   = {2'b00, in_reg.len1, 1'b0};
    assign dp_den   = dop_t'({1'b0, in_reg.len1}) + dop_t'({1'b0, in_reg.lend});
    assign dm_den   = dop_t'({1'b0, in_reg.len1}) + dop_t'({1'b0, in_reg.len2});

    always_comb
    begin
        res_t a_s;
        res_t b_s;
        a_s = q_sub(in_reg.u1, in_reg.u2);
        b_s = q_sub(in_reg.dv, in_reg.u1);
        d1_next = '0;
        d1_next.u1 = in_reg.u1;
        d1_next.a = a_s.val;
        d1_next.b = b_s.val;
        d1_next.fl_c = a_s.flag | b_s.flag;
        d1_next.fl_m = beta_num.flag | beta_den.flag;
    end

    mfr_div u_div_dp (.clk(clk), .en(pipe_en), .num(dp_num), .den(dp_den),
                      .quo(dp_q), .sat(dp_f));
    mfr_div u_div_dm (.clk(clk), .en(pipe_en), .num(dp_num), .den(dm_den),
                      .quo(dm_q), .sat(dm_f));
    mfr_div u_div_beta (.clk(clk), .en(pipe_en), .num(dop_t'(beta_num.val)),
                        .den(dop_t'(beta_den.val)), .quo(beta_q), .sat(beta_f));

    // scaled differences into multipliers
    always_comb
    begin
        m1a_next = d1_reg[DIV_LAT-1];
        m1a_next.p0 = mul_mag(m1a_next.b, dp_q);
        m1a_next.p1 = mul_mag(m1a_next.a, dm_q);
        m1a_next.p2 = mul_mag(m1a_next.b, beta_q);
        m1a_next.fl_c = m1a_next.fl_c | dp_f | dm_f;
        m1a_next.fl_m = m1a_next.fl_m | beta_f;
    end

    // ratio operands with bias, minmod limiter
    always_comb
    begin
        res_t pb_s;
        res_t pa_s;
        res_t bb_s;
        res_t nr_s;
        res_t dr_s;
        pb_s = mul_fin(m1a_reg.p0);
        pa_s = mul_fin(m1a_reg.p1);
        bb_s = mul_fin(m1a_reg.p2);
        nr_s = q_add(eps_w, pb_s.val);
        dr_s = q_add(eps_w, pa_s.val);
        m1b_next = m1a_reg;
        m1b_next.pa = pa_s.val;
        m1b_next.nr = nr_s.val;
        m1b_next.dr = dr_s.val;
        m1b_next.lim_mm = minmod(m1a_reg.a, bb_s.val);
        m1b_next.fl_c = m1a_reg.fl_c | pb_s.flag | pa_s.flag | nr_s.flag | dr_s.flag;
        m1b_next.fl_m = m1a_reg.fl_m | bb_s.flag;
    end

    mfr_div u_div_r (.clk(clk), .en(pipe_en), .num(dop_t'(m1b_reg.nr)),
                     .den(dop_t'(m1b_reg.dr)), .quo(r_q), .sat(r_f));

    // r squared
    always_comb
    begin
        m2a_next = d2_reg[DIV_LAT-1];
        m2a_next.r = r_q;
        m2a_next.fl_c = m2a_next.fl_c | r_f;
        m2a_next.p0 = mul_mag(r_q, r_q);
    end

    // van albada operands for r
    always_comb
    begin
        res_t x2_s;
        res_t vn_s;
        res_t vd_s;
        x2_s = mul_fin(m2a_reg.p0);
        vn_s = q_add(m2a_reg.r, x2_s.val);
        vd_s = q_add(ONE, x2_s.val);
        m2b_next = m2a_reg;
        m2b_next.vn = vn_s.val;
        m2b_next.vd = vd_s.val;
        m2b_next.fl_v = m2a_reg.fl_v | x2_s.flag | vn_s.flag | vd_s.flag;
    end

    mfr_div u_div_va1 (.clk(clk), .en(pipe_en), .num(dop_t'(m2b_reg.vn)),
                       .den(dop_t'(m2b_reg.vd)), .quo(va1_q), .sat(va1_f));
    mfr_div u_div_inv (.clk(clk), .en(pipe_en), .num(dop_t'(ONE)),
                       .den(dop_t'(m2b_reg.r)), .quo(inv_q), .sat(inv_f));
    mfr_div u_div_mi (.clk(clk), .en(pipe_en), .num(dop_t'(m2b_reg.lim_mm)),
                      .den(dop_t'(m2b_reg.r)), .quo(mi_q), .sat(mi_f));

    // 1/r squared
    always_comb
    begin
        m3a_next = d3_reg[DIV_LAT-1];
        m3a_next.lim_va = w_max('0, va1_q);
        m3a_next.s = inv_q;
        m3a_next.mi = mi_q;
        m3a_next.fl_v = m3a_next.fl_v | va1_f | inv_f;
        m3a_next.fl_m = m3a_next.fl_m | mi_f;
        m3a_next.p0 = mul_mag(inv_q, inv_q);
    end

    // van albada operands for 1/r
    always_comb
    begin
        res_t s2_s;
        res_t sn_s;
        res_t sd_s;
        s2_s = mul_fin(m3a_reg.p0);
        sn_s = q_add(m3a_reg.s, s2_s.val);
        sd_s = q_add(ONE, s2_s.val);
        m3b_next = m3a_reg;
        m3b_next.sn = sn_s.val;
        m3b_next.sd = sd_s.val;
        m3b_next.fl_v = m3a_reg.fl_v | s2_s.flag | sn_s.flag | sd_s.flag;
    end

    mfr_div u_div_va2 (.clk(clk), .en(pipe_en), .num(dop_t'(m3b_reg.sn)),
                       .den(dop_t'(m3b_reg.sd)), .quo(va2_q), .sat(va2_f));

    // limiter select and kappa weights
    always_comb
    begin
        res_t c1_s;
        res_t c2_s;
        c1_s = q_sub(ONE, k_w);
        c2_s = q_add(ONE, k_w);
        f1_next = d4_reg[DIV_LAT-1];
        f1_next.fl_v = f1_next.fl_v | va2_f;
        f1_next.c1 = c1_s.val;
        f1_next.c2 = c2_s.val;
        case (mode_reg)
            MODE_VA:
            begin
                f1_next.lim = f1_next.lim_va;
                f1_next.inv = w_max('0, va2_q);
                f1_next.fl_c = f1_next.fl_c | f1_next.fl_v;
            end
            MODE_MM:
            begin
                f1_next.lim = f1_next.lim_mm;
                f1_next.inv = f1_next.mi;
                f1_next.fl_c = f1_next.fl_c | f1_next.fl_m;
            end
            MODE_NONE:
            begin
                f1_next.lim = ONE;
                f1_next.inv = ONE;
            end
            default:
            begin
                f1_next.lim = ONE;
                f1_next.inv = ONE;
            end
        endcase
        f1_next.fl_c = f1_next.fl_c | c1_s.flag | c2_s.flag;
    end

    // quarter slope, weighted limiter, weighted ratio
    always_comb
    begin
        f2_next = f1_reg;
        f2_next.p0 = mul_mag(QUARTER, f1_reg.pa);
        f2_next.p1 = mul_mag(f1_reg.c1, f1_reg.lim);
        f2_next.p2 = mul_mag(f1_reg.c2, f1_reg.r);
    end

    always_comb
    begin
        res_t adm_s;
        res_t t1_s;
        res_t t2a_s;
        adm_s = mul_fin(f2_reg.p0);
        t1_s = mul_fin(f2_reg.p1);
        t2a_s = mul_fin(f2_reg.p2);
        f3_next = f2_reg;
        f3_next.adm = adm_s.val;
        f3_next.t1 = t1_s.val;
        f3_next.t2a = t2a_s.val;
        f3_next.fl_c = f2_reg.fl_c | adm_s.flag | t1_s.flag | t2a_s.flag;
    end

    // weighted ratio times inverse limiter
    always_comb
    begin
        f4_next = f3_reg;
        f4_next.p0 = mul_mag(f3_reg.t2a, f3_reg.inv);
    end

    // bracket sum
    always_comb
    begin
        res_t t2_s;
        res_t bk_s;
        t2_s = mul_fin(f4_reg.p0);
        bk_s = q_add(f4_reg.t1, t2_s.val);
        f5_next = f4_reg;
        f5_next.bkt = bk_s.val;
        f5_next.fl_c = f4_reg.fl_c | t2_s.flag | bk_s.flag;
    end

    always_comb
    begin
        f6_next = f5_reg;
        f6_next.p0 = mul_mag(f5_reg.adm, f5_reg.bkt);
    end

    // face value
    always_comb
    begin
        res_t pr_s;
        res_t fc_s;
        pr_s = mul_fin(f6_reg.p0);
        fc_s = q_add(f6_reg.u1, pr_s.val);
        face_next = fc_s.val;
        sat_next = f6_reg.fl_c | pr_s.flag | fc_s.flag;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            in_reg.u2   <= s_axis_tdata[0 +: W];
            in_reg.u1   <= s_axis_tdata[W +: W];
            in_reg.dv   <= s_axis_tdata[2*W +: W];
            in_reg.len1 <= s_axis_tdata[3*W +: LEN_W];
            in_reg.len2 <= s_axis_tdata[3*W+LEN_W +: LEN_W];
            in_reg.lend <= s_axis_tdata[3*W+2*LEN_W +: LEN_W];
            d1_reg[0] <= d1_next;
            d2_reg[0] <= m1b_reg;
            d3_reg[0] <= m2b_reg;
            d4_reg[0] <= m3b_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                d1_reg[i] <= d1_reg[i-1];
                d2_reg[i] <= d2_reg[i-1];
                d3_reg[i] <= d3_reg[i-1];
                d4_reg[i] <= d4_reg[i-1];
            end
            m1a_reg  <= m1a_next;
            m1b_reg  <= m1b_next;
            m2a_reg  <= m2a_next;
            m2b_reg  <= m2b_next;
            m3a_reg  <= m3a_next;
            m3b_reg  <= m3b_next;
            f1_reg   <= f1_next;
            f2_reg   <= f2_next;
            f3_reg   <= f3_next;
            f4_reg   <= f4_next;
            f5_reg   <= f5_next;
            f6_reg   <= f6_next;
            face_reg <= face_next;
            sat_reg  <= sat_next;
        end
    end

    // a stall freezes every valid bit
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted item not in first stage");

    // a new result comes only from the stage before the output
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(vld_reg[PIPE_LAT-2]))
        else $error("result without an item in the last stage");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mfr_pkg::*;

    localparam longint WHI = 64'sd2147483647;
    localparam longint WLO = -64'sd2147483648;
    localparam longint QONE = 64'sd65536;
    localparam int WATCH_LIMIT = 4000;

    typedef struct {
        logic [W-1:0]     far_up;
        logic [W-1:0]     near_up;
        logic [W-1:0]     down;
        logic [LEN_W-1:0] len_near;
        logic [LEN_W-1:0] len_far;
        logic [LEN_W-1:0] len_down;
    } cells_t;

    typedef struct {
        logic [W-1:0] face;
        logic         sat;
    } face_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // value_far_upwind, value_near_upwind, value_downwind,
    // len_near_upwind, len_far_upwind, len_downwind, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // face_value, saturated, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // configuration as the block should hold it
    logic [KAPPA_W-1:0] kappa_q;
    logic [MODE_W-1:0]  mode_q;
    logic [EPS_W-1:0]   eps_q;

    logic [IN_TDATA_W-1:0] pending_cells[$];
    face_t                 expected_faces[$];
    int  fail_count;
    int  idle_cycles;
    bit  in_taken;
    bit  out_taken;
    bit  burst_in;
    bit  burst_out;

    muscl_face_reconstruction_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // fixed point helpers
    function automatic longint clamp_word(input longint x, inout bit fl);
        if (x > WHI)
        begin
            fl = 1'b1;
            return WHI;
        end
        if (x < WLO)
        begin
            fl = 1'b1;
            return WLO;
        end
        return x;
    endfunction

    function automatic longint signed_mag(input bit neg, input logic [127:0] m, inout bit fl);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (m > lim)
        begin
            fl = 1'b1;
            m = lim;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [127:0] abs128(input longint x);
        return (x < 0) ? 128'(-x) : 128'(x);
    endfunction

    function automatic longint fx_mul(input longint x, input longint y, inout bit fl);
        logic [127:0] p;
        p = (abs128(x) * abs128(y) + 128'h8000) >> FRAC;
        return signed_mag((x < 0) != (y < 0), p, fl);
    endfunction

    function automatic longint fx_div(input longint x, input longint y, inout bit fl);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        if (y == 0)
        begin
            fl = 1'b1;
            return (x < 0) ? WLO : WHI;
        end
        num = abs128(x) << FRAC;
        den = abs128(y);
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem)
        begin
            quo = quo + 1;
        end
        return signed_mag((x < 0) != (y < 0), quo, fl);
    endfunction

    function automatic longint van_albada_fx(input longint x, inout bit fl);
        longint x2;
        longint t;
        x2 = fx_mul(x, x, fl);
        t = fx_div(clamp_word(x + x2, fl), clamp_word(QONE + x2, fl), fl);
        return (t > 0) ? t : 0;
    endfunction

    // expected face value of one item under the current configuration
    function automatic face_t reconstruct_face(input cells_t c);
        bit fl;
        longint u2, u1, dv, l1, l2, ld, k, eps;
        longint a, b, dp, dm, r, lim, inv, beta, bb, adm, brk, face;
        face_t f;
        fl = 1'b0;
        u2 = longint'($signed(c.far_up));
        u1 = longint'($signed(c.near_up));
        dv = longint'($signed(c.down));
        l1 = longint'(c.len_near);
        l2 = longint'(c.len_far);
        ld = longint'(c.len_down);
        k = longint'($signed(kappa_q));
        eps = longint'(eps_q);
        a = clamp_word(u1 - u2, fl);
        b = clamp_word(dv - u1, fl);
        dp = fx_div(l1 + l1, l1 + ld, fl);
        dm = fx_div(l1 + l1, l1 + l2, fl);
        r = fx_div(clamp_word(eps + fx_mul(b, dp, fl), fl),
                   clamp_word(eps + fx_mul(a, dm, fl), fl), fl);
        if (mode_q == MODE_VA)
        begin
            lim = van_albada_fx(r, fl);
            inv = van_albada_fx(fx_div(QONE, r, fl), fl);
        end
        else if (mode_q == MODE_MM)
        begin
            beta = fx_div(clamp_word(3 * QONE - k, fl), clamp_word(QONE - k, fl), fl);
            bb = fx_mul(b, beta, fl);
            if (a > 0)
            begin
                lim = (a < bb) ? a : bb;
                lim = (lim > 0) ? lim : 0;
            end
            else if (a < 0)
            begin
                lim = (a > bb) ? a : bb;
                lim = (lim < 0) ? lim : 0;
            end
            else
            begin
                lim = 0;
            end
            inv = fx_div(lim, r, fl);
        end
        else
        begin
            lim = QONE;
            inv = QONE;
        end
        adm = fx_mul(QONE / 4, fx_mul(a, dm, fl), fl);
        brk = clamp_word(fx_mul(clamp_word(QONE - k, fl), lim, fl)
                       + fx_mul(fx_mul(clamp_word(QONE + k, fl), r, fl), inv, fl), fl);
        face = clamp_word(u1 + fx_mul(adm, brk, fl), fl);
        f.face = face[W-1:0];
        f.sat = fl;
        return f;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_cells(input cells_t c);
        return IN_TDATA_W'({c.len_down, c.len_far, c.len_near, c.down, c.near_up, c.far_up});
    endfunction

    function automatic cells_t unpack_cells(input logic [IN_TDATA_W-1:0] d);
        cells_t c;
        c.far_up = d[W-1:0];
        c.near_up = d[2*W-1:W];
        c.down = d[3*W-1:2*W];
        c.len_near = d[3*W+LEN_W-1:3*W];
        c.len_far = d[3*W+2*LEN_W-1:3*W+LEN_W];
        c.len_down = d[3*W+3*LEN_W-1:3*W+2*LEN_W];
        return c;
    endfunction

    function automatic logic [W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom();
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'h0;
            default: return W'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] draw_len();
        case ($urandom_range(0, 9))
            0, 1: return LEN_W'($urandom());
            2: return '1;
            3: return '0;
            default: return LEN_W'($urandom_range(1, 32'h40000));
        endcase
    endfunction

    // smooth profile most of the time, arbitrary cells otherwise
    function automatic cells_t draw_cells();
        cells_t c;
        logic [W-1:0] base;
        logic [W-1:0] step;
        c.len_near = draw_len();
        c.len_far = draw_len();
        c.len_down = draw_len();
        if ($urandom_range(0, 2) != 0)
        begin
            base = W'($signed($urandom_range(0, 32'h200000)) - 32'sh100000);
            step = W'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            c.far_up = base;
            c.near_up = base + step + W'($urandom_range(0, 32'h8000));
            c.down = base + 2 * step + W'($urandom_range(0, 32'h8000));
            if ($urandom_range(0, 3) != 0)
            begin
                c.len_near = LEN_W'($urandom_range(32'h4000, 32'h30000));
                c.len_far = LEN_W'($urandom_range(32'h4000, 32'h30000));
                c.len_down = LEN_W'($urandom_range(32'h4000, 32'h30000));
            end
        end
        else
        begin
            c.far_up = draw_value();
            c.near_up = draw_value();
            c.down = draw_value();
        end
        return c;
    endfunction

    task automatic add_cells(input logic [W-1:0] u2, input logic [W-1:0] u1,
                             input logic [W-1:0] dv, input logic [LEN_W-1:0] l1,
                             input logic [LEN_W-1:0] l2, input logic [LEN_W-1:0] ld);
        cells_t c;
        c.far_up = u2;
        c.near_up = u1;
        c.down = dv;
        c.len_near = l1;
        c.len_far = l2;
        c.len_down = ld;
        pending_cells.push_back(pack_cells(c));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_KAPPA: kappa_q = val[KAPPA_W-1:0];
            CFG_MODE:  mode_q = val[MODE_W-1:0];
            CFG_EPS:   eps_q = val[EPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_cells.size() == 0 && !s_axis_tvalid && expected_faces.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(input int count);
        cells_t c;
        for (int i = 0; i < count; i++)
        begin
            c = draw_cells();
            pending_cells.push_back(pack_cells(c));
        end
    endtask

    task automatic directed_set();
        localparam logic [LEN_W-1:0] L1 = LEN_W'(32'h10000);
        add_cells(32'h0, 32'h10000, 32'h20000, L1, L1, L1);
        add_cells(32'h20000, 32'h10000, 32'h0, L1, L1, L1);
        add_cells(32'h0, 32'h10000, 32'h0, L1, L1, L1);
        add_cells(32'h10000, 32'h10000, 32'h10000, L1, L1, L1);
        add_cells(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, L1, L1, L1);
        add_cells(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, L1, L1, L1);
        add_cells(32'hFFFF_FFFF, 32'h0, 32'h1, '1, '1, '1);
        add_cells(32'h0, 32'h30000, 32'h40000, '0, L1, '0);
        add_cells(32'h0, 32'h30000, 32'h40000, '0, '0, L1);
        add_cells(32'h50000, 32'h30000, 32'h40000, '0, '0, '0);
        add_cells(32'h0, 32'h10000, 32'h30000, 31'd1, '1, 31'd1);
        add_cells(32'h0, 32'h10000, 32'h30000, '1, 31'd1, 31'd1);
        add_cells(32'hFFFF_0000, 32'h0, 32'h0002_0000, L1, LEN_W'(32'h20000), LEN_W'(32'h8000));
        add_cells(32'h1234_5678, 32'hEDCB_A987, 32'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555,
                  31'h7000_0001);
        add_cells(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_8000, L1, L1, L1);
    endtask

    // stimulus and configuration phases
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_KAPPA;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        kappa_q = '0;
        mode_q = MODE_NONE;
        eps_q = 16'd1;
        fail_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration
        directed_set();
        run_random(150);
        drain();

        write_reg(CFG_MODE, CFG_W'(MODE_VA));
        write_reg(CFG_KAPPA, CFG_W'(18'sd21845));
        write_reg(CFG_EPS, CFG_W'(16'd0));
        directed_set();
        run_random(200);
        drain();

        write_reg(CFG_MODE, CFG_W'(MODE_MM));
        write_reg(CFG_KAPPA, CFG_W'(-18'sd65536));
        write_reg(CFG_EPS, CFG_W'(16'hFFFF));
        directed_set();
        run_random(200);
        drain();

        // kappa of one makes beta divide by zero
        write_reg(CFG_KAPPA, CFG_W'(18'sd65536));
        directed_set();
        run_random(150);
        drain();

        // kappa register extremes beyond the meant range
        write_reg(CFG_KAPPA, CFG_W'(18'h1FFFF));
        write_reg(CFG_EPS, CFG_W'(16'd1));
        run_random(150);
        drain();
        write_reg(CFG_KAPPA, CFG_W'(18'h20000));
        run_random(150);
        drain();

        write_reg(CFG_MODE, CFG_W'(MODE_VA));
        write_reg(CFG_EPS, CFG_W'(16'h8000));
        run_random(200);
        drain();

        // unknown limiter code
        write_reg(CFG_MODE, CFG_W'(2'd3));
        write_reg(CFG_KAPPA, CFG_W'(-18'sd32768));
        directed_set();
        run_random(150);
        drain();

        write_reg(CFG_MODE, CFG_W'(MODE_MM));
        write_reg(CFG_KAPPA, CFG_W'(18'sd0));
        write_reg(CFG_EPS, CFG_W'(16'h5A5A));
        run_random(250);
        drain();

        repeat (PIPE_LAT + 20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // item driver
    always @(negedge clk)
    begin : drive_cells
        int gap;
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
                // hold the item
            end
            else if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap = gap - 1;
            end
            else if (pending_cells.size() != 0)
            begin
                s_axis_tdata <= pending_cells.pop_front();
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 40) == 0)
                begin
                    burst_in = !burst_in;
                end
                gap = burst_in ? 0 : $urandom_range(0, 7);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin : drive_ready
        int stall;
        if (rst_n)
        begin
            if (out_taken)
            begin
                if ($urandom_range(0, 40) == 0)
                begin
                    burst_out = !burst_out;
                end
                stall = burst_out ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall = stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // prediction, checking and watchdog
    always @(posedge clk)
    begin
        face_t want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        out_taken <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_faces.push_back(reconstruct_face(unpack_cells(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_faces.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item face=%h sat=%b", $time,
                             m_axis_tdata[W-1:0], m_axis_tdata[W]);
                end
                else
                begin
                    want = expected_faces.pop_front();
                    if (m_axis_tdata[W-1:0] !== want.face)
                    begin
                        fail_count++;
                        $display("%0t: face expected %h actual %h", $time,
                                 want.face, m_axis_tdata[W-1:0]);
                    end
                    if (m_axis_tdata[W] !== want.sat)
                    begin
                        fail_count++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.sat, m_axis_tdata[W]);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

endmodule

// File: files.f
hdl/mfr_pkg.sv
hdl/mfr_div.sv
hdl/muscl_face_reconstruction_top.sv
tb/testbench.sv
